@@ rtl/core/assert_macros.svh @@
// Assertion macros for the text console writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TCW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

    // Field widths of the stream beats.
    localparam int REQ_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int DATA_W    = 16;
    localparam int POS_OUT_W = 11;
    localparam int COLOR_W   = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Request codes carried on the input tuser.
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Special characters and cell values.
    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'h20;
    localparam logic [DATA_W-1:0]  BLANK_CELL   = 16'h0F20;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h02;

    // Controller states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_PUT,
        ST_CLEAR,
        ST_RD,
        ST_FIN
    } state_t;

endpackage

@@ rtl/core/tcw_screen_ram.sv @@
// Screen cell memory: one write port, one read port with registered data.
module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tcw_pkg::DATA_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tcw_pkg::DATA_W-1:0]  rdata
);

    logic [tcw_pkg::DATA_W-1:0] mem [DEPTH];
    logic [tcw_pkg::DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tcw_ctrl.sv @@
// Request sequencer: cursor, screen sweeps, put/read handling and result register.
`include "assert_macros.svh"

module tcw_ctrl #(
    parameter  int COLUMNS = 80,
    parameter  int ROWS    = 25,
    localparam int CELLS   = ROWS * COLUMNS,
    localparam int AW      = $clog2(CELLS)
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [tcw_pkg::COLOR_W-1:0]    color,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [tcw_pkg::REQ_W-1:0]      in_type,
    input  logic [tcw_pkg::CHAR_W-1:0]     in_char,
    input  logic [tcw_pkg::IDX_W-1:0]      in_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tcw_pkg::DATA_W-1:0]     out_data,
    output logic [tcw_pkg::POS_OUT_W-1:0]  out_pos,
    output logic                           mem_we,
    output logic [AW-1:0]                  mem_waddr,
    output logic [tcw_pkg::DATA_W-1:0]     mem_wdata,
    output logic [AW-1:0]                  mem_raddr,
    input  logic [tcw_pkg::DATA_W-1:0]     mem_rdata
);

    localparam int CW  = $clog2(CELLS + 1);
    localparam int RW  = $clog2(ROWS + 1);
    localparam int CLW = $clog2(COLUMNS);
    localparam int IW  = (CW > tcw_pkg::IDX_W) ? CW : tcw_pkg::IDX_W;

    localparam logic [CW-1:0]  CNT_LAST   = CW'(CELLS - 1);
    localparam logic [CW-1:0]  CNT_END    = CW'(CELLS);
    localparam logic [CW-1:0]  COPY_LIMIT = CW'(CELLS - COLUMNS);
    localparam logic [CW-1:0]  COLS_CNT   = CW'(COLUMNS);
    localparam logic [RW-1:0]  ROW_BELOW  = RW'(ROWS);
    localparam logic [RW-1:0]  ROW_LAST   = RW'(ROWS - 1);
    localparam logic [CLW-1:0] COL_LAST   = CLW'(COLUMNS - 1);
    localparam logic [IW-1:0]  IDX_LIMIT  = IW'(CELLS);

    tcw_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CLW-1:0] col_reg, col_next;
    logic [CW-1:0]  pos_reg, pos_next;

    logic [tcw_pkg::CHAR_W-1:0]    ch_reg, ch_next;
    logic                          oor_reg, oor_next;
    logic [tcw_pkg::DATA_W-1:0]    data_reg, data_next;
    logic                          m_valid_reg;
    logic [tcw_pkg::DATA_W-1:0]    m_data_reg;
    logic [tcw_pkg::POS_OUT_W-1:0] m_pos_reg;

    logic                       accept;
    logic                       slot_free;
    logic                       push;
    logic [tcw_pkg::DATA_W-1:0] push_data;
    logic [IW-1:0]              idx_ext;
    logic                       idx_in_range;

    // Put datapath outputs.
    logic [tcw_pkg::CHAR_W-1:0] put_char;
    logic                       put_we;
    logic [AW-1:0]              put_addr;
    logic [tcw_pkg::DATA_W-1:0] put_wdata;
    logic [RW-1:0]              put_row;
    logic [CLW-1:0]             put_col;
    logic [CW-1:0]              put_pos;

    assign accept       = (state_reg == tcw_pkg::ST_IDLE) && in_valid;
    assign slot_free    = !m_valid_reg || out_ready;
    assign idx_ext      = IW'(in_index);
    assign idx_in_range = idx_ext < IDX_LIMIT;
    assign put_char     = (state_reg == tcw_pkg::ST_IDLE) ? in_char : ch_reg;

    // Effect of one put request on the cursor and the screen.
    always_comb begin
        put_we    = 1'b0;
        put_addr  = pos_reg[AW-1:0];
        put_wdata = {color, put_char};
        put_row   = row_reg;
        put_col   = col_reg;
        put_pos   = pos_reg;
        if (put_char == tcw_pkg::CH_NEWLINE) begin
            put_col = '0;
            put_row = RW'(row_reg + 1'b1);
            put_pos = CW'(pos_reg - CW'(col_reg) + COLS_CNT);
        end else if (put_char == tcw_pkg::CH_BACKSPACE) begin
            if (col_reg != '0) begin
                put_we    = 1'b1;
                put_addr  = AW'(pos_reg - 1'b1);
                put_wdata = {color, tcw_pkg::CH_SPACE};
                put_col   = CLW'(col_reg - 1'b1);
                put_pos   = CW'(pos_reg - 1'b1);
            end
        end else begin
            put_we  = 1'b1;
            put_pos = CW'(pos_reg + 1'b1);
            if (col_reg == COL_LAST) begin
                put_col = '0;
                put_row = RW'(row_reg + 1'b1);
            end else begin
                put_col = CLW'(col_reg + 1'b1);
            end
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_INIT: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_type)
                        tcw_pkg::REQ_PUT: begin
                            state_next = (row_reg == ROW_BELOW) ? tcw_pkg::ST_SCROLL
                                                                : tcw_pkg::ST_FIN;
                        end
                        tcw_pkg::REQ_READ:  state_next = tcw_pkg::ST_RD;
                        tcw_pkg::REQ_CLEAR: state_next = tcw_pkg::ST_CLEAR;
                        default:            state_next = tcw_pkg::ST_FIN;
                    endcase
                end
            end
            tcw_pkg::ST_SCROLL: begin
                if (cnt_reg == CNT_END) begin
                    state_next = tcw_pkg::ST_PUT;
                end
            end
            tcw_pkg::ST_PUT: state_next = tcw_pkg::ST_FIN;
            tcw_pkg::ST_CLEAR: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = tcw_pkg::ST_FIN;
                end
            end
            tcw_pkg::ST_RD: state_next = slot_free ? tcw_pkg::ST_IDLE : tcw_pkg::ST_FIN;
            tcw_pkg::ST_FIN: begin
                if (slot_free) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default: state_next = tcw_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates per state.
    always_comb begin
        cnt_next  = cnt_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        pos_next  = pos_reg;
        ch_next   = ch_reg;
        oor_next  = oor_reg;
        data_next = data_reg;
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = tcw_pkg::BLANK_CELL;
        mem_raddr = idx_ext[AW-1:0];
        push      = 1'b0;
        push_data = data_reg;
        in_ready  = 1'b0;
        unique case (state_reg)
            tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
                // Blank one cell per cycle.
                mem_we   = 1'b1;
                cnt_next = (cnt_reg == CNT_LAST) ? '0 : CW'(cnt_reg + 1'b1);
            end
            tcw_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    ch_next   = in_char;
                    oor_next  = !idx_in_range;
                    data_next = '0;
                    cnt_next  = '0;
                    if (in_type == tcw_pkg::REQ_PUT && row_reg != ROW_BELOW) begin
                        mem_we    = put_we;
                        mem_waddr = put_addr;
                        mem_wdata = put_wdata;
                        row_next  = put_row;
                        col_next  = put_col;
                        pos_next  = put_pos;
                    end else if (in_type == tcw_pkg::REQ_CLEAR) begin
                        row_next = '0;
                        col_next = '0;
                        pos_next = '0;
                    end
                end
            end
            tcw_pkg::ST_SCROLL: begin
                // Read the cell one row below, write it one row up in the following cycle; the last row is blanked.
                mem_raddr = AW'(cnt_reg + COLS_CNT);
                if (cnt_reg != '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(cnt_reg - 1'b1);
                    mem_wdata = (cnt_reg <= COPY_LIMIT) ? mem_rdata : tcw_pkg::BLANK_CELL;
                end
                if (cnt_reg == CNT_END) begin
                    cnt_next = '0;
                    row_next = ROW_LAST;
                    pos_next = CW'(pos_reg - COLS_CNT);
                end else begin
                    cnt_next = CW'(cnt_reg + 1'b1);
                end
            end
            tcw_pkg::ST_PUT: begin
                mem_we    = put_we;
                mem_waddr = put_addr;
                mem_wdata = put_wdata;
                row_next  = put_row;
                col_next  = put_col;
                pos_next  = put_pos;
            end
            tcw_pkg::ST_RD: begin
                push_data = oor_reg ? '0 : mem_rdata;
                data_next = push_data;
                push      = slot_free;
            end
            tcw_pkg::ST_FIN: begin
                push = slot_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcw_pkg::ST_INIT;
            cnt_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        ch_reg   <= ch_next;
        oor_reg  <= oor_next;
        data_reg <= data_next;
        if (push) begin
            m_data_reg <= push_data;
            m_pos_reg  <= tcw_pkg::POS_OUT_W'(pos_reg);
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;
    assign out_pos   = m_pos_reg;

    `TCW_ASSERT(a_pos_matches, aclk, aresetn, pos_reg == CW'(row_reg * COLUMNS + col_reg), "linear cursor out of step with row and column")
    `TCW_ASSERT(a_cursor_range, aclk, aresetn, (col_reg <= COL_LAST) && (row_reg <= ROW_BELOW), "cursor outside the screen")
    `TCW_ASSERT(a_push_slot, aclk, aresetn, !push || slot_free, "result pushed over an untaken beat")
    `TCW_ASSERT_NEXT(a_put_fast, aclk, aresetn, accept && in_type == tcw_pkg::REQ_PUT && row_reg != ROW_BELOW, state_reg == tcw_pkg::ST_FIN, "plain put did not finish in one cycle")

endmodule

@@ rtl/core/text_console_writer.sv @@
// A put or read beat goes from the accepting cycle through ST_FIN or ST_RD into the result register behind m_tvalid.
// A new beat is taken only in ST_IDLE, after the state that loads the result; a full result register holds ST_FIN.
// A put with the cursor below the last row first scrolls the screen up in ST_SCROLL, then writes in ST_PUT.
// Clear walks the cell memory, blanking every cell, then sends its result from ST_FIN.
// Reset (aresetn low, synchronous) homes the cursor and sets the color to 0x02, then a
// clearing pass over all ROWS*COLUMNS cells (2000 by default) blanks the screen before input.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0]     cfg_wdata,   // text_color
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,     // char_code[7:0], cell_index[18:8]
    input  logic [tcw_pkg::REQ_W-1:0]       s_tuser,     // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata      // cell_data[15:0], cursor_pos[26:16]
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int PAD_W = tcw_pkg::M_TDATA_W - tcw_pkg::DATA_W - tcw_pkg::POS_OUT_W;

    logic [tcw_pkg::COLOR_W-1:0]   color_reg;
    logic [tcw_pkg::DATA_W-1:0]    out_data;
    logic [tcw_pkg::POS_OUT_W-1:0] out_pos;
    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [tcw_pkg::DATA_W-1:0]    mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [tcw_pkg::DATA_W-1:0]    mem_rdata;

    // Text color register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= tcw_pkg::COLOR_RESET;
        end else if (cfg_we) begin
            color_reg <= cfg_wdata;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .color     (color_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_type   (s_tuser),
        .in_char   (s_tdata[tcw_pkg::CHAR_W-1:0]),
        .in_index  (s_tdata[tcw_pkg::CHAR_W +: tcw_pkg::IDX_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .out_pos   (out_pos),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result beat packing.
    assign m_tdata = {{PAD_W{1'b0}}, out_pos, out_data};

endmodule

@@ test/console_screen_checker.sv @@
// Scoreboard for the text console writer: predicts every result beat and compares it.
module console_screen_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [tcw_pkg::REQ_W-1:0]       s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                              failures,
    output int                              pending_results
);
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [DATA_W-1:0]    cell_data;
        logic [POS_OUT_W-1:0] cursor_pos;
    } screen_reply_t;

    // Shadow copy of the screen, the cursor and the color register.
    logic [DATA_W-1:0]  screen [CELLS];
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    logic [COLOR_W-1:0] text_color;

    screen_reply_t expected_replies[$];
    int fail_total;
    int replies_seen;

    // Move every line up by one and blank the bottom line.
    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = BLANK_CELL;
        end
    endfunction

    // A put first scrolls if the cursor has gone past the last row.
    function automatic void put_char(logic [CHAR_W-1:0] ch);
        if (cur_row >= ROWS) begin
            scroll_screen();
            cur_row = ROW_W'(ROWS - 1);
        end
        if (ch == CH_NEWLINE) begin
            cur_col = '0;
            cur_row++;
        end else if (ch == CH_BACKSPACE) begin
            // Backspace at the start of a line does nothing.
            if (cur_col > 0) begin
                cur_col--;
                screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {text_color, CH_SPACE};
            end
        end else begin
            screen[int'(cur_row) * COLUMNS + int'(cur_col)] = {text_color, ch};
            if (int'(cur_col) == COLUMNS - 1) begin
                cur_col = '0;
                cur_row++;
            end else begin
                cur_col++;
            end
        end
    endfunction

    // Apply one request to the shadow state and return the reply it should produce.
    function automatic screen_reply_t serve_request(logic [REQ_W-1:0] req,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [IDX_W-1:0] idx);
        screen_reply_t reply;
        reply.cell_data = '0;
        case (req)
            REQ_PUT: begin
                put_char(ch);
            end
            REQ_READ: begin
                if (idx < CELLS) begin
                    reply.cell_data = screen[idx];
                end
            end
            REQ_CLEAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i] = BLANK_CELL;
                end
                cur_row = '0;
                cur_col = '0;
            end
            default: begin
            end
        endcase
        reply.cursor_pos = POS_OUT_W'(int'(cur_row) * COLUMNS + int'(cur_col));
        return reply;
    endfunction

    task automatic note_failure(string msg);
        fail_total++;
        if (fail_total <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    // Watch both channels and the register port at every edge.
    always @(posedge aclk) begin
        screen_reply_t got;
        screen_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                screen[i] = BLANK_CELL;
            end
            cur_row = '0;
            cur_col = '0;
            text_color = COLOR_RESET;
            expected_replies.delete();
        end else begin
            if (cfg_we) begin
                text_color = cfg_wdata;
            end
            // The outgoing beat belongs to an older request, so it is checked first.
            if (m_tvalid && m_tready) begin
                got.cell_data  = m_tdata[DATA_W-1:0];
                got.cursor_pos = m_tdata[DATA_W+POS_OUT_W-1:DATA_W];
                replies_seen++;
                if (expected_replies.size() == 0) begin
                    note_failure($sformatf("Result beat %0d arrived with none expected: tdata %h",
                                           replies_seen, m_tdata));
                end else begin
                    want = expected_replies.pop_front();
                    if (got.cell_data !== want.cell_data) begin
                        note_failure($sformatf("Result beat %0d cell_data: expected %h, got %h",
                                               replies_seen, want.cell_data, got.cell_data));
                    end
                    if (got.cursor_pos !== want.cursor_pos) begin
                        note_failure($sformatf("Result beat %0d cursor_pos: expected %0d, got %0d",
                                               replies_seen, want.cursor_pos, got.cursor_pos));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_replies.push_back(serve_request(s_tuser, s_tdata[CHAR_W-1:0],
                                                         s_tdata[CHAR_W+IDX_W-1:CHAR_W]));
            end
        end
        failures <= fail_total;
        pending_results <= expected_replies.size();
    end

endmodule

@@ test/text_console_writer_test.sv @@
// Testbench top for the text console writer: clock, reset, stimulus, flow control and verdict.
module text_console_writer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tcw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 215;
    localparam int CALM_FROM      = 1200;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [COLOR_W-1:0]    cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    int   failures;
    int   pending_results;
    int   items_sent;
    int   idle_cycles;
    logic calm_tail;
    logic tx_gappy;

    // Receiver-side bookkeeping.
    int   results_taken;
    int   stall_left;
    int   hold_left;
    int   stall_window;
    logic hold_done;
    logic rx_gappy;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    console_screen_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) screen_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .failures       (failures),
        .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Give up when no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, one long hold to back the block up, none at the end.
    initial begin
        m_tready <= 1'b0;
        hold_done = 1'b0;
        rx_gappy = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                results_taken++;
            end
            if (stall_window == 0) begin
                stall_window = 256;
                rx_gappy = ($urandom_range(0, 2) != 0);
            end
            stall_window--;
            if (!hold_done && results_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm_tail && rx_gappy && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 15);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one request beat and hold it until the block takes it.
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        if (!calm_tail && tx_gappy && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_TDATA_W-CHAR_W-IDX_W){1'b0}}, idx, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (items_sent == CALM_FROM) begin
            calm_tail <= 1'b1;
        end
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(REQ_PUT, ch, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        send_item(REQ_READ, CHAR_W'($urandom_range(0, 255)), idx);
    endtask

    // Mostly printable text, now and then any byte at all.
    function automatic logic [CHAR_W-1:0] text_char();
        if ($urandom_range(0, 7) == 0) begin
            return CHAR_W'($urandom_range(0, 255));
        end
        return CHAR_W'($urandom_range(32, 126));
    endfunction

    // Reads favor the top and bottom rows; text lands in the bottom rows after scrolling.
    function automatic logic [IDX_W-1:0] read_index();
        case ($urandom_range(0, 3))
            0: return IDX_W'($urandom_range(0, CELLS - 1));
            1: return IDX_W'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
            2: return IDX_W'($urandom_range(0, 3 * COLUMNS - 1));
            default: return IDX_W'($urandom_range(0, 2047));
        endcase
    endfunction

    // Change the color only once every expected result is back.
    task automatic write_color(input logic [COLOR_W-1:0] color);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= color;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One burst of related requests.
    task automatic run_sequence();
        int kind;
        int count;
        kind = $urandom_range(0, 199);
        if (kind < 80) begin
            count = $urandom_range(1, 60);
            repeat (count) put_char(text_char());
        end else if (kind < 110) begin
            count = $urandom_range(1, 12);
            repeat (count) put_char(CH_NEWLINE);
        end else if (kind < 130) begin
            count = $urandom_range(1, 10);
            repeat (count) put_char(CH_BACKSPACE);
        end else if (kind < 180) begin
            count = $urandom_range(1, 6);
            repeat (count) read_cell(read_index());
        end else if (kind < 183) begin
            send_item(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)), IDX_W'($urandom_range(0, 2047)));
        end else if (kind < 190) begin
            send_item(REQ_UNUSED, CHAR_W'($urandom_range(0, 255)),
                      IDX_W'($urandom_range(0, 2047)));
        end else begin
            send_item(REQ_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                      IDX_W'($urandom_range(0, 2047)));
        end
    endtask

    initial begin
        int phase_start;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_PUT;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        aresetn   <= 1'b0;
        calm_tail <= 1'b0;
        tx_gappy = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, backspace cases, reads at and past the end, clear.
        read_cell(IDX_W'(0));
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(CH_BACKSPACE);
        read_cell(IDX_W'(2));
        read_cell(IDX_W'(0));
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        read_cell(IDX_W'(CELLS - 1));
        read_cell(IDX_W'(CELLS));
        read_cell(IDX_W'(2047));
        send_item(REQ_UNUSED, 8'hFF, IDX_W'(2047));
        send_item(REQ_CLEAR, 8'h00, IDX_W'(0));
        read_cell(IDX_W'(0));

        // Random phases, each under its own text color.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                end
                1: write_color(8'h00);
                2: write_color(8'hFF);
                5: write_color(8'h5A);
                default: write_color(COLOR_W'($urandom_range(0, 255)));
            endcase
            phase_start = items_sent;
            if (phase == 0) begin
                // Run off the bottom, then newline and backspace there both scroll.
                repeat (ROWS) put_char(CH_NEWLINE);
                put_char(CH_NEWLINE);
                put_char(CH_BACKSPACE);
                repeat (COLUMNS + 3) put_char(text_char());
                read_cell(IDX_W'(CELLS - COLUMNS));
            end
            while (items_sent - phase_start < PHASE_ITEMS) begin
                tx_gappy = ($urandom_range(0, 2) != 0);
                run_sequence();
            end
        end

        // Drain and give the verdict.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (failures == 0 && pending_results == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
